// ===== hdl/aesl_pkg.sv =====
// Package for the ANSI escape stripping line assembler.
// Holds the character codes and the command type passed from the parser to the line unit.
// No dependencies.
package aesl_pkg;

  localparam logic [7:0] CH_ESC = 8'h1B;
  localparam logic [7:0] CH_BEL = 8'h07;
  localparam logic [7:0] CH_BS  = 8'h08;
  localparam logic [7:0] CH_CR  = 8'h0D;
  localparam logic [7:0] CH_LF  = 8'h0A;
  localparam logic [7:0] CH_LBR = 8'h5B;
  localparam logic [7:0] CH_RBR = 8'h5D;
  localparam logic [7:0] CH_BSL = 8'h5C;

  // Number of commands the queue between parser and line unit can hold.
  localparam int unsigned QUEUE_DEPTH = 2;

  typedef enum logic [1:0] {
    CMD_APPEND,
    CMD_BACKSPACE,
    CMD_CLEAR,
    CMD_EMIT
  } cmd_op_t;

  typedef struct packed {
    cmd_op_t    op;
    logic [7:0] data;
  } cmd_t;

endpackage

// ===== hdl/aesl_front.sv =====
// Parser front end: accepts raw bytes, tracks escape state and turns plain-text bytes
// into line commands. Depends on aesl_pkg.
module aesl_front (
  input  logic          clk,
  input  logic          rst,
  input  logic [7:0]    byte_in,
  input  logic          byte_valid,
  output logic          byte_ready,
  output logic          cmd_push,
  output aesl_pkg::cmd_t cmd,
  input  logic          queue_full
);
  import aesl_pkg::*;

  typedef enum logic [1:0] {
    MODE_PLAIN,
    MODE_ESC,
    MODE_CSI,
    MODE_OSC
  } mode_t;

  mode_t mode, mode_next;
  logic  prev_esc, prev_esc_next;
  logic  has_cmd;
  logic  accept;

  assign byte_ready = !queue_full;
  assign accept     = byte_valid && byte_ready;
  assign cmd_push   = accept && has_cmd;

  always_comb begin
    mode_next     = mode;
    prev_esc_next = prev_esc;
    has_cmd       = 1'b0;
    cmd.op        = CMD_APPEND;
    cmd.data      = byte_in;
    case (mode)
      MODE_ESC: begin
        if (byte_in == CH_LBR) begin
          mode_next = MODE_CSI;
        end else if (byte_in == CH_RBR) begin
          mode_next     = MODE_OSC;
          prev_esc_next = 1'b0;
        end else begin
          mode_next = MODE_PLAIN;
        end
      end
      MODE_CSI: begin
        if (byte_in inside {[8'h41:8'h5A], [8'h61:8'h7A]}) begin
          mode_next = MODE_PLAIN;
        end
      end
      MODE_OSC: begin
        if (byte_in == CH_BEL || (byte_in == CH_BSL && prev_esc)) begin
          mode_next     = MODE_PLAIN;
          prev_esc_next = 1'b0;
        end else begin
          prev_esc_next = (byte_in == CH_ESC);
        end
      end
      default: begin
        if (byte_in == CH_ESC) begin
          mode_next = MODE_ESC;
        end else if (byte_in == CH_BEL) begin
          has_cmd = 1'b0;
        end else if (byte_in == CH_BS) begin
          has_cmd = 1'b1;
          cmd.op  = CMD_BACKSPACE;
        end else if (byte_in == CH_CR) begin
          has_cmd = 1'b1;
          cmd.op  = CMD_CLEAR;
        end else if (byte_in == CH_LF) begin
          has_cmd = 1'b1;
          cmd.op  = CMD_EMIT;
        end else begin
          has_cmd = 1'b1;
          cmd.op  = CMD_APPEND;
        end
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      mode     <= MODE_PLAIN;
      prev_esc <= 1'b0;
    end else if (accept) begin
      mode     <= mode_next;
      prev_esc <= prev_esc_next;
    end
  end

endmodule

// ===== hdl/aesl_queue.sv =====
// Short command queue between the parser and the line unit.
// Depends on aesl_pkg for the command type and depth.
module aesl_queue (
  input  logic           clk,
  input  logic           rst,
  input  logic           push,
  input  aesl_pkg::cmd_t push_cmd,
  output logic           full,
  input  logic           pop,
  output aesl_pkg::cmd_t pop_cmd,
  output logic           not_empty
);
  import aesl_pkg::*;

  localparam int unsigned PTR_W = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
  localparam int unsigned CNT_W = $clog2(QUEUE_DEPTH + 1);

  cmd_t             entries [QUEUE_DEPTH];
  logic [PTR_W-1:0] wr_ptr;
  logic [PTR_W-1:0] rd_ptr;
  logic [CNT_W-1:0] count;
  logic             do_push, do_pop;

  assign full      = (count == CNT_W'(QUEUE_DEPTH));
  assign not_empty = (count != '0);
  assign do_push   = push && !full;
  assign do_pop    = pop && not_empty;
  assign pop_cmd   = entries[rd_ptr];

  always_ff @(posedge clk) begin
    if (do_push) begin
      entries[wr_ptr] <= push_cmd;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (do_push) begin
        wr_ptr <= (wr_ptr == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr + 1'b1;
      end
      if (do_pop) begin
        rd_ptr <= (rd_ptr == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr + 1'b1;
      end
      if (do_push && !do_pop) begin
        count <= count + 1'b1;
      end else if (do_pop && !do_push) begin
        count <= count - 1'b1;
      end
    end
  end

endmodule

// ===== hdl/aesl_back.sv =====
// Line unit: executes line commands against the line store and drains finished lines
// through a registered output. Depends on aesl_pkg.
module aesl_back #(
  parameter int unsigned LINE_MAX = 63
) (
  input  logic           clk,
  input  logic           rst,
  input  logic           cmd_valid,
  input  aesl_pkg::cmd_t cmd,
  output logic           cmd_pop,
  output logic [7:0]     char_out,
  output logic           line_end,
  output logic           truncated,
  output logic           char_valid,
  input  logic           char_ready
);
  import aesl_pkg::*;

  localparam int unsigned LEN_W = $clog2(LINE_MAX + 1);
  localparam int unsigned IDX_W = (LINE_MAX > 1) ? $clog2(LINE_MAX) : 1;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_DRAIN,
    ST_FETCH
  } state_t;

  state_t           state;
  logic [7:0]       line_mem [LINE_MAX];
  logic [7:0]       rd_data;
  logic [LEN_W-1:0] length;
  logic [LEN_W-1:0] rd_idx;
  logic             overflow;
  logic             out_free;
  logic             out_load;
  logic             wr_en;
  logic             rd_en;

  assign out_free = !char_valid || char_ready;
  assign out_load = out_free && ((state == ST_FETCH) ||
                                 ((state == ST_DRAIN) && !(rd_idx < length)));
  assign cmd_pop  = (state == ST_IDLE) && cmd_valid;
  assign wr_en    = cmd_pop && (cmd.op == CMD_APPEND) && (length < LEN_W'(LINE_MAX));
  assign rd_en    = (state == ST_DRAIN) && (rd_idx < length);

  always_ff @(posedge clk) begin
    if (wr_en) begin
      line_mem[length[IDX_W-1:0]] <= cmd.data;
    end
    if (rd_en) begin
      rd_data <= line_mem[rd_idx[IDX_W-1:0]];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= ST_IDLE;
      length     <= '0;
      rd_idx     <= '0;
      overflow   <= 1'b0;
      char_valid <= 1'b0;
    end else begin
      if (out_load) begin
        char_valid <= 1'b1;
      end else if (char_valid && char_ready) begin
        char_valid <= 1'b0;
      end
      case (state)
        ST_IDLE: begin
          if (cmd_valid) begin
            case (cmd.op)
              CMD_APPEND: begin
                if (length < LEN_W'(LINE_MAX)) begin
                  length <= length + 1'b1;
                end else begin
                  overflow <= 1'b1;
                end
              end
              CMD_BACKSPACE: begin
                if (length != '0) begin
                  length <= length - 1'b1;
                end
              end
              CMD_CLEAR: begin
                length <= '0;
              end
              CMD_EMIT: begin
                rd_idx <= '0;
                state  <= ST_DRAIN;
              end
              default: begin
                state <= ST_IDLE;
              end
            endcase
          end
        end
        ST_DRAIN: begin
          if (rd_idx < length) begin
            state <= ST_FETCH;
          end else if (out_free) begin
            char_out   <= CH_LF;
            line_end   <= 1'b1;
            truncated  <= overflow;
            length     <= '0;
            overflow   <= 1'b0;
            state      <= ST_IDLE;
          end
        end
        ST_FETCH: begin
          if (out_free) begin
            char_out   <= rd_data;
            line_end   <= 1'b0;
            truncated  <= overflow;
            rd_idx     <= rd_idx + 1'b1;
            state      <= ST_DRAIN;
          end
        end
        default: begin
          state <= ST_IDLE;
        end
      endcase
    end
  end

endmodule

// ===== hdl/ansi_escape_strip_line_assembler.sv =====
// Top level of the ANSI escape stripping line assembler.
// Instantiates aesl_front, aesl_queue and aesl_back; depends on aesl_pkg.
//
// Usage:
//   Input channel (byte_in, byte_valid, byte_ready) takes one raw terminal byte
//   per request. Escape sequences (CSI, OSC and two-byte escapes) are removed,
//   BEL is dropped, backspace and CR edit the pending line, LF ends it, and
//   every other byte is appended to a line store of LINE_MAX bytes. Bytes
//   beyond that are dropped and the line is marked truncated.
//   Output channel (char_out, line_end, truncated, char_valid, char_ready)
//   delivers a finished line one character per request on LF, ending with an
//   LF request that has line_end set.
//   Throughput: the parser takes one byte per cycle while byte_ready is high.
//   Each command goes through a two-entry queue to the line unit, which
//   executes the edits while it is idle. A line drains one character per
//   pass through the DRAIN and FETCH states, set by the registered read port
//   of the line store, and the closing LF follows; while it drains the queue
//   fills and byte_ready then falls.
//   When the receiver stalls, the output register holds its request and the
//   drain waits; bytes already in the queue stay there.
//   Reset clears the escape state, the queue, the line length and the
//   truncation flag; the store contents need no clearing.
module ansi_escape_strip_line_assembler #(
  parameter int unsigned LINE_MAX = 63
) (
  input  logic       clk,
  input  logic       rst,
  input  logic [7:0] byte_in,
  input  logic       byte_valid,
  output logic       byte_ready,
  output logic [7:0] char_out,
  output logic       line_end,
  output logic       truncated,
  output logic       char_valid,
  input  logic       char_ready
);
  import aesl_pkg::*;

  cmd_t front_cmd;
  cmd_t back_cmd;
  logic front_push;
  logic queue_full;
  logic queue_not_empty;
  logic back_pop;

  // The parser turns bytes into line commands; escape bytes produce none.
  aesl_front u_front (
    .clk        (clk),
    .rst        (rst),
    .byte_in    (byte_in),
    .byte_valid (byte_valid),
    .byte_ready (byte_ready),
    .cmd_push   (front_push),
    .cmd        (front_cmd),
    .queue_full (queue_full)
  );

  // The queue lets the parser keep running while the line unit drains a line.
  aesl_queue u_queue (
    .clk       (clk),
    .rst       (rst),
    .push      (front_push),
    .push_cmd  (front_cmd),
    .full      (queue_full),
    .pop       (back_pop),
    .pop_cmd   (back_cmd),
    .not_empty (queue_not_empty)
  );

  // The line unit owns the store, the length and the truncation flag.
  aesl_back #(
    .LINE_MAX (LINE_MAX)
  ) u_back (
    .clk        (clk),
    .rst        (rst),
    .cmd_valid  (queue_not_empty),
    .cmd        (back_cmd),
    .cmd_pop    (back_pop),
    .char_out   (char_out),
    .line_end   (line_end),
    .truncated  (truncated),
    .char_valid (char_valid),
    .char_ready (char_ready)
  );

endmodule
